// ===== sv/stream_substring_matcher_defines.svh =====
// Assertion macros for the substring matcher checker
`ifndef STREAM_SUBSTRING_MATCHER_DEFINES_SVH
`define STREAM_SUBSTRING_MATCHER_DEFINES_SVH

// clocked assertion, off while reset is held
`define SSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/ssm_pkg.sv =====
// Shared constants and types of the substring matcher
`default_nettype none
package ssm_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int MAX_TEXT      = 1024;

  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W         = $clog2(MAX_TEXT + 1);
  localparam int CFG_LEN_W     = 6;
  localparam int OFF_W         = 10;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int NUM_PAT_REGS  = 4;
  localparam int BYTES_PER_REG = 8;
  localparam int CFG_PAT_BYTES = NUM_PAT_REGS * BYTES_PER_REG;

  localparam int OUT_W         = 1 + OFF_W + 1;
  localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_0 = 3'd1;

  // pattern as the cells see it: byte k is compared against window byte k
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] bytes;
    logic [MAX_PATTERN-1:0]      en;
    logic [LEN_W-1:0]            eff_len;
    logic                        len_zero;
  } pat_cfg_t;

endpackage
`default_nettype wire

// ===== sv/stream_substring_matcher.sv =====
// Top level of the streaming substring matcher
// Usage:
//  - Slave stream carries the text, one byte per word: tdata[7:0] is the byte,
//    tlast marks the final byte of a text.
//  - Master stream carries one result word per text, sent after the tlast word.
//  - Configuration: write pattern_length (index 0) and the pattern bytes
//    (indices 1 to 4, eight bytes each) between words; a write applies from
//    the next word on.
//  - Throughput: one text byte per cycle while s_axis_tready_o is high. A row
//    of 32 window cells shifts the text along and compares every position
//    against the pattern in the cycle the byte is taken.
//  - Result: the result word is valid in the cycle after the tlast word is taken.
//  - Stall: the result sits in an output register; input keeps flowing until a
//    second tlast word arrives while that register is still held, then
//    s_axis_tready_o drops until the result is taken.
//  - Reset: pattern_length returns to 1, pattern bytes to zero, search state
//    and output valid are cleared (the result data is not reset). No clearing pass.
//  - Texts longer than 1024 bytes: later bytes are ignored and text_too_long is set.
`default_nettype none
module stream_substring_matcher (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [7:0]                       s_axis_tdata_i,  // [7:0] text_byte
  input  wire logic                             s_axis_tlast_i,  // end_of_text
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [0] pattern_found, [10:1] match_offset, [11] text_too_long, rest zero
  output logic [ssm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ssm_pkg::*;

  pat_cfg_t               pat_cfg;
  logic [MAX_PATTERN-1:0] hit;
  logic [7:0]             chain [MAX_PATTERN+1];

  logic             acc, sat, shift, match, long_enough;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc, cnt_nx;
  logic             found_q, found_d, found_nx;
  logic [OFF_W-1:0] off_q, off_d, off_nx;
  logic             ovf_q, ovf_d, ovf_nx;
  logic             m_valid_q, m_valid_d;
  logic [OUT_W-1:0] m_data_q, m_data_d;
  logic             res_found;
  logic [OFF_W-1:0] res_off;

  ssm_pattern_regs u_pattern_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pat_cfg_o  (pat_cfg)
  );

  assign chain[0] = s_axis_tdata_i;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    ssm_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .byte_i    (chain[k]),
      .pat_byte_i(pat_cfg.bytes[k]),
      .en_i      (pat_cfg.en[k]),
      .byte_o    (chain[k+1]),
      .hit_o     (hit[k])
    );
  end

  // only a final byte needs the result register free
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i || !s_axis_tlast_i;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign sat             = (cnt_q == CNT_W'(MAX_TEXT));
  assign shift           = acc && !sat;
  assign cnt_inc         = CNT_W'(cnt_q + 1'b1);
  assign long_enough     = (int'(cnt_inc) >= int'(pat_cfg.eff_len));

  always_comb begin
    match    = shift && !found_q && !pat_cfg.len_zero && long_enough && (&hit);
    found_nx = found_q || match;
    off_nx   = match ? OFF_W'(int'(cnt_inc) - int'(pat_cfg.eff_len)) : off_q;
    cnt_nx   = shift ? cnt_inc : cnt_q;
    ovf_nx   = ovf_q || (acc && sat);

    res_found = pat_cfg.len_zero || found_nx;
    res_off   = (pat_cfg.len_zero || !found_nx) ? '0 : off_nx;

    cnt_d     = cnt_nx;
    found_d   = found_nx;
    off_d     = off_nx;
    ovf_d     = ovf_nx;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    if (acc && s_axis_tlast_i) begin
      cnt_d     = '0;
      found_d   = 1'b0;
      off_d     = '0;
      ovf_d     = 1'b0;
      m_valid_d = 1'b1;
      m_data_d  = {ovf_nx, res_off, res_found};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      found_q   <= 1'b0;
      off_q     <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      off_q     <= off_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-OUT_W){1'b0}}, m_data_q};

endmodule
`default_nettype wire

// ===== sv/ssm_cell.sv =====
// One window cell: holds a text byte, compares its incoming byte with the pattern
`default_nettype none
module ssm_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] pat_byte_i,
  input  wire logic       en_i,
  output logic      [7:0] byte_o,
  output logic            hit_o
);
  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = !en_i || (byte_i == pat_byte_i);

endmodule
`default_nettype wire

// ===== sv/ssm_pattern_regs.sv =====
// Configuration registers and the cell-aligned pattern image
`default_nettype none
module ssm_pattern_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ssm_pkg::pat_cfg_t                   pat_cfg_o
);
  import ssm_pkg::*;

  logic [MAX_PATTERN-1:0][7:0] pattern_q, pattern_d;
  logic [CFG_LEN_W-1:0]        len_q, len_d;
  pat_cfg_t                    cfg_q, cfg_d;
  logic [MAX_PATTERN-1:0][7:0] pat_rev;
  logic [LEN_W-1:0]            eff;
  logic [LEN_W-1:0]            sh;

  always_comb begin
    pattern_d = pattern_q;
    len_d     = len_q;
    if (cfg_we_i && cfg_index_i == REG_PATTERN_LENGTH) begin
      len_d = cfg_data_i[CFG_LEN_W-1:0];
    end
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if (p < CFG_PAT_BYTES) begin
        if (cfg_we_i && cfg_index_i ==
            CFG_IDX_W'(int'(REG_PATTERN_BYTES_0) + p / BYTES_PER_REG)) begin
          pattern_d[p] = cfg_data_i[8*(p % BYTES_PER_REG) +: 8];
        end
      end
    end
  end

  // aligned byte k = pattern[eff-1-k]: reverse, then shift down by MAX_PATTERN-eff
  always_comb begin
    if (int'(len_d) > MAX_PATTERN) begin
      eff = LEN_W'(MAX_PATTERN);
    end else begin
      eff = LEN_W'(len_d);
    end
    sh = LEN_W'(MAX_PATTERN) - eff;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_rev[i] = pattern_d[MAX_PATTERN-1-i];
    end
    cfg_d.bytes    = pat_rev >> {sh, 3'b000};
    cfg_d.en       = {MAX_PATTERN{1'b1}} >> sh;
    cfg_d.eff_len  = eff;
    cfg_d.len_zero = (len_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q      <= '0;
      len_q          <= CFG_LEN_W'(1);
      cfg_q.bytes    <= '0;
      cfg_q.en       <= MAX_PATTERN'(1);
      cfg_q.eff_len  <= LEN_W'(1);
      cfg_q.len_zero <= 1'b0;
    end else begin
      pattern_q <= pattern_d;
      len_q     <= len_d;
      cfg_q     <= cfg_d;
    end
  end

  assign pat_cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/ssm_checker.sv =====
// Port-level checker for the substring matcher, bound to the top level
`default_nettype none
`include "stream_substring_matcher_defines.svh"
module ssm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [7:0]                     s_axis_tdata_i,
  input wire logic                           s_axis_tlast_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [ssm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import ssm_pkg::*;

  `SSM_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result word changed while stalled")
  `SSM_ASSERT(a_result_after_last, $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i), "result word without a final text byte")
  `SSM_ASSERT(a_offset_zero, m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[OFF_W:1] == '0, "offset set without a match")
  `SSM_ASSERT(a_ready_only_on_stall, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i, "input held off without an output stall")
  `SSM_ASSERT_ALWAYS(a_pad_zero, !m_axis_tvalid_o || m_axis_tdata_o[OUT_TDATA_W-1:OUT_W] == '0, "padding bits not zero")

endmodule

bind stream_substring_matcher ssm_checker u_ssm_checker (.*);
`default_nettype wire

// ===== bench/stream_substring_matcher_tb.sv =====
// Testbench of the streaming substring matcher: directed and random texts and patterns, words checked in order
`timescale 1ns / 100ps
module stream_substring_matcher_tb;
  import ssm_pkg::*;

  typedef struct packed {
    logic             too_long;
    logic [OFF_W-1:0] offset;
    logic             found;
  } match_result_t;

  // mirrors the search state and holds the results still owed by the block
  class match_tracker;
    logic [7:0]     pat [MAX_PATTERN];
    logic [5:0]     pat_len;
    logic [7:0]     window [MAX_PATTERN];
    int unsigned    seen;
    bit             found;
    bit             overflow;
    logic [OFF_W-1:0] first_off;
    match_result_t  expected_matches [$];
    int             errors;

    function new();
      foreach (pat[i]) pat[i] = 8'h00;
      pat_len = 6'd1;
      errors  = 0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (window[i]) window[i] = 8'h00;
      seen      = 0;
      found     = 1'b0;
      overflow  = 1'b0;
      first_off = '0;
    endfunction

    function int unsigned active_length();
      return (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      int slot;
      slot = int'(idx);
      if (idx == REG_PATTERN_LENGTH) begin
        pat_len = val[5:0];
      end else if (slot >= int'(REG_PATTERN_BYTES_0) &&
                   slot < int'(REG_PATTERN_BYTES_0) + NUM_PAT_REGS) begin
        for (int b = 0; b < BYTES_PER_REG; b++)
          pat[(slot - int'(REG_PATTERN_BYTES_0)) * BYTES_PER_REG + b] = val[8*b +: 8];
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned   len;
      bit            hit;
      match_result_t res;
      len = active_length();
      if (seen >= MAX_TEXT) begin
        overflow = 1'b1;
      end else begin
        for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        seen++;
        if (len > 0 && seen >= len && !found) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++)
            if (pat[j] != window[len-1-j]) hit = 1'b0;
          if (hit) begin
            found     = 1'b1;
            first_off = OFF_W'(seen - len);
          end
        end
      end
      if (last) begin
        res.found    = (len == 0) ? 1'b1 : found;
        res.offset   = (len != 0 && found) ? first_off : '0;
        res.too_long = overflow;
        expected_matches.push_back(res);
        clear_search();
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      match_result_t got;
      match_result_t want;
      got = word[OUT_W-1:0];
      if (expected_matches.size() == 0) begin
        $error("result word %h with no text pending", word);
        errors++;
        return;
      end
      want = expected_matches.pop_front();
      if (got.found !== want.found) begin
        $error("pattern_found: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.offset !== want.offset) begin
        $error("match_offset: expected %0d, got %0d", want.offset, got.offset);
        errors++;
      end
      if (got.too_long !== want.too_long) begin
        $error("text_too_long: expected %0d, got %0d", want.too_long, got.too_long);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [7:0]             s_axis_tdata_i;   // [7:0] text_byte
  logic                   s_axis_tlast_i;   // end_of_text
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [0] found, [10:1] offset, [11] too long
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  match_tracker sb;
  logic [7:0]   text_q [$];
  bit           narrow;
  bit           no_gaps;
  bit           long_done;
  int unsigned  random_items;
  int unsigned  phase;

  stream_substring_matcher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= no_gaps || ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o) sb.take_byte(s_axis_tdata_i, s_axis_tlast_i);
    end
  end

  function automatic logic [7:0] rand_byte();
    return narrow ? 8'(8'h61 + $urandom_range(1)) : 8'($urandom_range(255));
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.apply_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [7:0] b, input logic last);
    while (!no_gaps && $urandom_range(99) < 16) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_matches.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic plant(input int unsigned pos, input bit broken);
    int unsigned elen;
    elen = sb.active_length();
    for (int j = 0; j < elen; j++) text_q[pos+j] = sb.pat[j];
    if (broken) text_q[pos+elen-1] = ~sb.pat[elen-1];
  endtask

  // random text, usually with a copy (or a near miss) of the pattern inside
  task automatic make_text(input int unsigned n);
    int unsigned elen;
    int unsigned k;
    text_q.delete();
    repeat (n) text_q.push_back(rand_byte());
    elen = sb.active_length();
    k    = $urandom_range(9);
    if (elen != 0 && elen <= n && k < 7)
      repeat ((k < 2) ? 2 : 1) plant($urandom_range(n - elen), k >= 5);
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] val;
    int unsigned           len;
    int unsigned           pick;
    pick = $urandom_range(9);
    case (pick)
      0:       len = 0;
      1:       len = $urandom_range(MAX_PATTERN + 1, 63);
      2:       len = MAX_PATTERN;
      3:       len = 1;
      default: len = $urandom_range(2, 12);
    endcase
    narrow = $urandom_range(3) != 0;
    for (int r = 0; r < NUM_PAT_REGS; r++) begin
      for (int b = 0; b < BYTES_PER_REG; b++) val[8*b +: 8] = rand_byte();
      cfg_write(CFG_IDX_W'(int'(REG_PATTERN_BYTES_0) + r), val);
    end
    val      = {$urandom, $urandom};
    val[5:0] = len[5:0];
    cfg_write(REG_PATTERN_LENGTH, val);
    if ($urandom_range(3) == 0)
      cfg_write(CFG_IDX_W'(int'(REG_PATTERN_BYTES_0) + NUM_PAT_REGS + $urandom_range(2)),
                {$urandom, $urandom});
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    sb              = new();
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_PATTERN_LENGTH;
    cfg_data_i      = '0;
    narrow          = 1'b0;
    no_gaps         = 1'b0;
    long_done       = 1'b0;
    random_items    = 0;
    phase           = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset pattern: a single zero byte
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF, 8'h00};
    send_text();
    settle();

    cfg_write(REG_PATTERN_LENGTH, 64'd3);
    cfg_write(REG_PATTERN_BYTES_0, 64'h7F00FF);
    text_q = '{8'hFF, 8'h00};
    send_text();
    text_q = '{8'h12, 8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h7F};
    send_text();
    settle();

    // empty pattern matches at once
    cfg_write(REG_PATTERN_LENGTH, 64'd0);
    text_q = '{8'h55};
    send_text();
    settle();

    // length clipped to the window size, text shorter than the pattern
    cfg_write(REG_PATTERN_LENGTH, 64'd40);
    text_q = '{8'hFF, 8'h00, 8'h7F};
    send_text();
    settle();

    while (random_items < 950) begin
      no_gaps = (phase >= 3 && phase < 7);
      random_setup();
      // over-long text: a copy past the counter range, a copy or near miss ending on the last counted byte
      if (!long_done && random_items >= 400) begin
        make_text(MAX_TEXT + 1 + $urandom_range(15));
        if (sb.active_length() != 0) begin
          plant(text_q.size() - sb.active_length(), 1'b0);
          plant(MAX_TEXT - sb.active_length(), bit'($urandom_range(1)));
        end
        random_items += text_q.size();
        send_text();
        long_done = 1'b1;
      end
      repeat ($urandom_range(3, 8)) begin
        make_text($urandom_range(1, sb.active_length() + 24));
        random_items += text_q.size();
        send_text();
      end
      settle();
      phase++;
    end

    settle();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ssm_pkg.sv
sv/ssm_cell.sv
sv/ssm_pattern_regs.sv
sv/stream_substring_matcher.sv
sv/ssm_checker.sv
bench/stream_substring_matcher_tb.sv
